// ===== hw/rtl/lbw_pkg.sv =====
// Shared constants for the 3x3 sliding-window line buffer.
// Used by the line buffer top level and its checker; depends on nothing.

package lbw_pkg;

	// Window edge length in pixels.
	localparam int WIN = 3;

	// Default sizes for the top-level parameters.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_PIXEL_BITS = 8;

	// Configuration port layout.
	localparam int CFG_BITS       = 11;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [CFG_BITS-1:0] SIZE_RESET = 11'd1024;

endpackage

// ===== hw/rtl/line_buffer_window_3x3.sv =====
// Top level of the 3x3 sliding-window line buffer: counters, two line stores
// and a 3x3 chain of tap cells. Depends on lbw_pkg, lbw_ram and lbw_cell.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in      | to block  | in_valid / in_stall  | pixel
//   out     | from block| out_valid / out_stall| tap_* (9), window_valid, frame_end
//   cfg     | to block  | cfg_we               | cfg_index, cfg_data
//
// One pixel per clock is sustained while the output is not stalled; the line
// stores are read in the cycle a request is taken and written back as it leaves the stage.
// A taken request is registered in one stage and then in the window registers,
// which double as the output register.
// After reset the line stores read as zero through a fill count, so there is
// no clearing pass and requests are taken from the first cycle.
// A stalled output holds the window; one further request is held in the stage.

module line_buffer_window_3x3 #(
	parameter int MAX_WIDTH  = lbw_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lbw_pkg::DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = lbw_pkg::DEF_PIXEL_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               cfg_we,
	input  logic [lbw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [lbw_pkg::CFG_BITS-1:0]       cfg_data,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [PIXEL_BITS-1:0]              pixel,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [PIXEL_BITS-1:0]              tap_top_left,
	output logic [PIXEL_BITS-1:0]              tap_top_mid,
	output logic [PIXEL_BITS-1:0]              tap_top_right,
	output logic [PIXEL_BITS-1:0]              tap_mid_left,
	output logic [PIXEL_BITS-1:0]              tap_mid_mid,
	output logic [PIXEL_BITS-1:0]              tap_mid_right,
	output logic [PIXEL_BITS-1:0]              tap_bot_left,
	output logic [PIXEL_BITS-1:0]              tap_bot_mid,
	output logic [PIXEL_BITS-1:0]              tap_bot_right,
	output logic                               window_valid,
	output logic                               frame_end
);

	localparam int COL_BITS  = $clog2(MAX_WIDTH);
	localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
	localparam int FILL_BITS = $clog2(MAX_WIDTH + 1);
	localparam int WCMP = (lbw_pkg::CFG_BITS > COL_BITS + 1) ? lbw_pkg::CFG_BITS : COL_BITS + 1;
	localparam int HCMP = (lbw_pkg::CFG_BITS > ROW_BITS + 1) ? lbw_pkg::CFG_BITS : ROW_BITS + 1;
	localparam int WIN  = lbw_pkg::WIN;

	// Configuration registers.
	logic [lbw_pkg::CFG_BITS-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lbw_pkg::SIZE_RESET;
			height_q <= lbw_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lbw_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				lbw_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sizes in use, clamped to the legal range.
	logic [WCMP-1:0] width_raw, width_use;
	logic [HCMP-1:0] height_raw, height_use;

	always_comb begin
		width_raw = WCMP'(width_q);
		if (width_raw < WCMP'(WIN)) begin
			width_use = WCMP'(WIN);
		end else if (width_raw > WCMP'(MAX_WIDTH)) begin
			width_use = WCMP'(MAX_WIDTH);
		end else begin
			width_use = width_raw;
		end
		height_raw = HCMP'(height_q);
		if (height_raw < HCMP'(WIN)) begin
			height_use = HCMP'(WIN);
		end else if (height_raw > HCMP'(MAX_HEIGHT)) begin
			height_use = HCMP'(MAX_HEIGHT);
		end else begin
			height_use = height_raw;
		end
	end

	// Handshake and stage control.
	logic s1_valid_q, out_valid_q;
	logic advance, accept;

	assign advance  = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !advance;
	assign accept   = in_valid && !in_stall;

	// Raster counters and the fill count of the line stores.
	logic [COL_BITS-1:0]  col_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [FILL_BITS-1:0] fill_q;
	logic                 last_col, last_row;

	assign last_col = (WCMP'(col_q) + WCMP'(1)) >= width_use;
	assign last_row = (HCMP'(row_q) + HCMP'(1)) >= height_use;

	// Columns are always visited in order from zero, so the entries written so
	// far are exactly those below the fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + COL_BITS'(1);
			end
			if (FILL_BITS'(col_q) >= fill_q) begin
				fill_q <= FILL_BITS'(col_q) + FILL_BITS'(1);
			end
		end
	end

	// Stage 1: the line store read is in flight.
	logic [PIXEL_BITS-1:0] pixel_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic                  hit_s1, wvalid_s1, fend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1  <= pixel;
			col_s1    <= col_q;
			hit_s1    <= FILL_BITS'(col_q) < fill_q;
			wvalid_s1 <= (row_q >= ROW_BITS'(2)) && (col_q >= COL_BITS'(2));
			fend_s1   <= last_col && last_row;
		end
	end

	// Line stores. Writing back shifts the column down by one row.
	logic [PIXEL_BITS-1:0] upper_rd, middle_rd, up_px, mid_px;

	assign up_px  = hit_s1 ? upper_rd  : '0;
	assign mid_px = hit_s1 ? middle_rd : '0;

	lbw_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_upper_line (
		.clk   (clk),
		.we    (advance),
		.waddr (col_s1),
		.wdata (mid_px),
		.re    (accept),
		.raddr (col_q),
		.rdata (upper_rd)
	);

	lbw_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_middle_line (
		.clk   (clk),
		.we    (advance),
		.waddr (col_s1),
		.wdata (pixel_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (middle_rd)
	);

	// Window: three rows of three cells, each shifting left on advance.
	logic [PIXEL_BITS-1:0] right_col [WIN];
	logic [PIXEL_BITS-1:0] tap       [WIN][WIN];

	assign right_col[0] = up_px;
	assign right_col[1] = mid_px;
	assign right_col[2] = pixel_s1;

	for (genvar r = 0; r < WIN; r++) begin : g_row
		for (genvar c = 0; c < WIN; c++) begin : g_col
			lbw_cell #(
				.PIXEL_BITS (PIXEL_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (advance),
				.din      ((c == WIN - 1) ? right_col[r] : tap[r][(c + 1) % WIN]),
				.dout     (tap[r][c])
			);
		end
	end

	// Output flags sit alongside the window cells.
	logic window_valid_q, frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			window_valid_q <= wvalid_s1;
			frame_end_q    <= fend_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign window_valid  = window_valid_q;
	assign frame_end     = frame_end_q;
	assign tap_top_left  = tap[0][0];
	assign tap_top_mid   = tap[0][1];
	assign tap_top_right = tap[0][2];
	assign tap_mid_left  = tap[1][0];
	assign tap_mid_mid   = tap[1][1];
	assign tap_mid_right = tap[1][2];
	assign tap_bot_left  = tap[2][0];
	assign tap_bot_mid   = tap[2][1];
	assign tap_bot_right = tap[2][2];

endmodule

// ===== hw/rtl/lbw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instanced once for each line store.

module lbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/lbw_cell.sv =====
// One tap of the 3x3 window: a pixel register that takes its right-hand
// neighbour's value on each shift. No package dependencies.

module lbw_cell #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift_en,
	input  logic [PIXEL_BITS-1:0] din,
	output logic [PIXEL_BITS-1:0] dout
);

	logic [PIXEL_BITS-1:0] tap_q;

	// The window is visible before it fills, so it must start at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (shift_en) begin
			tap_q <= din;
		end
	end

	assign dout = tap_q;

endmodule

// ===== hw/rtl/lbw_checker.sv =====
// Port-level checker for the 3x3 sliding-window line buffer, bound to the
// top level. Depends on lbw_pkg and line_buffer_window_3x3.

module lbw_checker #(
	parameter int PIXEL_BITS = lbw_pkg::DEF_PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [PIXEL_BITS-1:0] tap_top_mid,
	input  logic [PIXEL_BITS-1:0] tap_top_right,
	input  logic [PIXEL_BITS-1:0] tap_bot_mid,
	input  logic [PIXEL_BITS-1:0] tap_bot_right,
	input  logic                  window_valid,
	input  logic                  frame_end
);

	logic                  out_take;
	logic                  have_prev_q, prev_end_q;
	logic [PIXEL_BITS-1:0] prev_bot_right_q, prev_top_right_q;

	assign out_take = out_valid && !out_stall;

	// The previous result delivered, for checking the window shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q      <= 1'b0;
			prev_end_q       <= 1'b0;
			prev_bot_right_q <= '0;
			prev_top_right_q <= '0;
		end else if (out_take) begin
			have_prev_q      <= 1'b1;
			prev_end_q       <= frame_end;
			prev_bot_right_q <= tap_bot_right;
			prev_top_right_q <= tap_top_right;
		end
	end

	// A result that is stalled stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// Each result shifts the bottom row by one pixel.
	a_bot_shift: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q |-> tap_bot_mid == prev_bot_right_q)
		else $error("bottom row did not shift from the previous result");

	// The top row shifts in step with the bottom row.
	a_top_shift: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q |-> tap_top_mid == prev_top_right_q)
		else $error("top row did not shift from the previous result");

	// The first pixel of a frame can never carry a full window.
	a_new_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q && prev_end_q |-> !window_valid)
		else $error("window marked valid on the first pixel of a frame");

endmodule

bind line_buffer_window_3x3 lbw_checker #(
	.PIXEL_BITS (PIXEL_BITS)
) u_lbw_checker (.*);
